FILE: hdl/ntc_pkg.sv
// Shared types, codes and output-order tables for the near-plane clipper.
`default_nettype none
package ntc_pkg;

  localparam int NCOMP = 8;

  // One vertex: components x, y, z, w, attr_0..attr_3 at indices 0..7.
  typedef logic [NCOMP-1:0][31:0] vtx_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_w;
    logic signed [31:0] attr_0;
    logic signed [31:0] attr_1;
    logic signed [31:0] attr_2;
    logic signed [31:0] attr_3;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         out_corner;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic signed [31:0] out_attr_0;
    logic signed [31:0] out_attr_1;
    logic signed [31:0] out_attr_2;
    logic signed [31:0] out_attr_3;
    logic               end_of_triangle;
    logic               end_of_run;
  } out_item_t;

  // Which corners are behind the near plane.
  typedef enum logic [2:0] {
    CLIP_AB, CLIP_AC, CLIP_A, CLIP_BC, CLIP_B, CLIP_C, CLIP_NONE
  } clip_case_t;

  typedef enum logic [1:0] { EDGE_AB, EDGE_AC, EDGE_BC } edge_t;

  // Source of one emitted vertex.
  typedef enum logic [2:0] { SRC_A, SRC_B, SRC_C, SRC_X, SRC_Y } src_t;

  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;

  // Request from the front end to the back end.
  typedef struct packed {
    clip_case_t ccase;
    vtx_t       a;
    vtx_t       b;
    vtx_t       c;
  } job_t;

  typedef enum logic [2:0] {
    BE_IDLE, BE_SETUP, BE_DIV, BE_SAT, BE_MUL, BE_ADD, BE_EMIT
  } be_state_t;

  function automatic edge_t edge_x(clip_case_t cc);
    edge_t e;
    unique case (cc)
      CLIP_AB, CLIP_C:                   e = EDGE_AC;
      CLIP_AC, CLIP_A, CLIP_BC, CLIP_B:  e = EDGE_AB;
      default:                           e = EDGE_AB;
    endcase
    return e;
  endfunction

  function automatic edge_t edge_y(clip_case_t cc);
    edge_t e;
    unique case (cc)
      CLIP_A, CLIP_BC: e = EDGE_AC;
      default:         e = EDGE_BC;
    endcase
    return e;
  endfunction

  function automatic logic [2:0] seq_len(clip_case_t cc);
    logic [2:0] n;
    unique case (cc)
      CLIP_A, CLIP_B, CLIP_C: n = 3'd6;
      default:                n = 3'd3;
    endcase
    return n;
  endfunction

  function automatic src_t seq_src(clip_case_t cc, logic [2:0] k);
    src_t s;
    s = SRC_A;
    unique case (cc)
      CLIP_AB: s = (k == 3'd0) ? SRC_Y : (k == 3'd1) ? SRC_C : SRC_X;
      CLIP_AC: s = (k == 3'd0) ? SRC_X : (k == 3'd1) ? SRC_B : SRC_Y;
      CLIP_BC: s = (k == 3'd0) ? SRC_Y : (k == 3'd1) ? SRC_A : SRC_X;
      CLIP_A: begin
        unique case (k)
          3'd0:       s = SRC_X;
          3'd1, 3'd4: s = SRC_B;
          3'd2, 3'd3: s = SRC_Y;
          default:    s = SRC_C;
        endcase
      end
      CLIP_B: begin
        unique case (k)
          3'd0:       s = SRC_Y;
          3'd1, 3'd4: s = SRC_C;
          3'd2, 3'd3: s = SRC_X;
          default:    s = SRC_A;
        endcase
      end
      CLIP_C: begin
        unique case (k)
          3'd0:       s = SRC_X;
          3'd1, 3'd4: s = SRC_A;
          3'd2, 3'd3: s = SRC_Y;
          default:    s = SRC_B;
        endcase
      end
      default: s = (k == 3'd0) ? SRC_A : (k == 3'd1) ? SRC_B : SRC_C;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/near_plane_triangle_clipper.sv
// Top level of the near-plane triangle clipper.
// Vertices enter one request per cycle while full is low; corners 0 and 1
// are held in the front end. A triangle that survives is queued (two deep)
// for the back end, which for each crossing edge runs a bit-serial divide of
// t (skipped when the denominator is zero) and then the eight multiply/add
// steps, two crossings per clipped triangle, then emits 3 or 6 vertices one at
// a time. An unclipped triangle goes straight to emission. Results are held in
// an output register and leave through empty/pop.
`default_nettype none
module near_plane_triangle_clipper
  import ntc_pkg::*;
#(
  parameter int VARY_DIM  = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  vertex,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      result
);

  logic q_push, q_full, q_pop, q_nonempty;
  job_t q_wdata, q_rdata;

  assign full = q_full;

  ntc_front #(.VARY_DIM(VARY_DIM)) u_front (
    .clk(clk), .rst(rst), .vertex(vertex), .accept(push && !q_full),
    .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
  );

  ntc_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .full(q_full), .nonempty(q_nonempty), .rdata(q_rdata)
  );

  ntc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .q_nonempty(q_nonempty), .q_data(q_rdata),
    .q_pop(q_pop), .result(result), .empty(empty), .pop(pop)
  );

endmodule
`default_nettype wire

FILE: hdl/ntc_front.sv
// Front end: holds corners 0 and 1, classifies each triangle, issues requests.
`default_nettype none
module ntc_front
  import ntc_pkg::*;
#(
  parameter int VARY_DIM = 8
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t vertex,
  input  wire logic     accept,
  input  wire logic     q_full,
  output logic          q_push,
  output job_t          q_data
);

  vtx_t       slot0;
  vtx_t       slot1;
  vtx_t       cur;
  logic [1:0] corner_count;
  logic       ca, cb, cc;

  // Unpack and zero components past the varying count.
  always_comb begin
    cur = {vertex.attr_3, vertex.attr_2, vertex.attr_1, vertex.attr_0,
           vertex.pos_w, vertex.pos_z, vertex.pos_y, vertex.pos_x};
    for (int i = 0; i < NCOMP; i++) begin
      if (i >= VARY_DIM) cur[i] = '0;
    end
  end

  function automatic logic clipped(vtx_t v);
    logic signed [32:0] s;
    s = 33'(signed'(v[3])) + 33'(signed'(v[2]));
    return (signed'(v[3]) <= 0) || (s < 0);
  endfunction

  assign ca = clipped(slot0);
  assign cb = clipped(slot1);
  assign cc = clipped(cur);

  // Classification into one of the clip cases.
  always_comb begin
    q_data.a = slot0;
    q_data.b = slot1;
    q_data.c = cur;
    priority if (ca && cb) q_data.ccase = CLIP_AB;
    else if (ca && cc)     q_data.ccase = CLIP_AC;
    else if (ca)           q_data.ccase = CLIP_A;
    else if (cb && cc)     q_data.ccase = CLIP_BC;
    else if (cb)           q_data.ccase = CLIP_B;
    else if (cc)           q_data.ccase = CLIP_C;
    else                   q_data.ccase = CLIP_NONE;
  end

  assign q_push = accept && (vertex.corner == CORNER_2) && (corner_count == 2'd2)
                  && !(ca && cb && cc) && !q_full;

  // Held corners.
  always_ff @(posedge clk) begin
    if (accept && vertex.corner == CORNER_0) slot0 <= cur;
    if (accept && vertex.corner == CORNER_1) slot1 <= cur;
  end

  // Corner sequence tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= 2'd0;
    end else if (accept) begin
      unique case (vertex.corner)
        CORNER_0: corner_count <= 2'd1;
        CORNER_1: corner_count <= (corner_count == 2'd1) ? 2'd2 : 2'd0;
        CORNER_2: corner_count <= 2'd0;
        default:  corner_count <= corner_count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ntc_queue.sv
// Two-entry request queue between front and back ends.
`default_nettype none
module ntc_queue
  import ntc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wdata,
  input  wire logic pop,
  output logic      full,
  output logic      nonempty,
  output job_t      rdata
);

  job_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ntc_back.sv
// Back end: edge crossings (serial divide, per-component lerp) and emission.
`default_nettype none
module ntc_back
  import ntc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_nonempty,
  input  wire job_t      q_data,
  output logic           q_pop,
  output out_item_t      result,
  output logic           empty,
  input  wire logic      pop
);

  localparam int NW = 33 + FRAC_BITS;
  localparam int CW = $clog2(NW);
  localparam logic [NW-1:0] QMAX = NW'(33'h07fffffff);
  localparam logic [NW-1:0] QMIN = NW'(33'h080000000);

  be_state_t state, state_next;
  job_t      job;
  logic      ysel;
  vtx_t      xv, yv;
  logic [2:0] comp;
  logic [2:0] k;
  logic signed [31:0] t;
  logic [NW-1:0] dvd;
  logic [33:0]   dvs;
  logic [33:0]   rem;
  logic [CW-1:0] cnt;
  logic          qneg;
  logic signed [64:0] prod;
  logic          out_valid;

  edge_t              cur_edge;
  vtx_t               pa, pb;
  logic signed [32:0] num;
  logic signed [33:0] den;
  logic [34:0]        trial;
  logic               fit;
  logic signed [64:0] shv;
  logic signed [65:0] sum;
  logic signed [31:0] sat;
  logic signed [32:0] diff;
  logic               load;
  src_t               src;
  vtx_t               ov;

  // Endpoints of the edge under work.
  assign cur_edge = ysel ? edge_y(job.ccase) : edge_x(job.ccase);
  assign pa  = (cur_edge == EDGE_BC) ? job.b : job.a;
  assign pb  = (cur_edge == EDGE_AB) ? job.b : job.c;
  assign num = 33'(signed'(pa[2])) + 33'(signed'(pa[3]));
  assign den = 34'(num) - 34'(signed'(pb[2])) - 34'(signed'(pb[3]));

  // Restoring divide step.
  assign trial = {rem, dvd[NW-1]};
  assign fit   = trial >= {1'b0, dvs};

  // Lerp: floor shift, add, saturate.
  assign diff = 33'(signed'(pb[comp])) - 33'(signed'(pa[comp]));
  assign shv  = prod >>> FRAC_BITS;
  assign sum  = 66'(signed'(pa[comp])) + 66'(shv);
  always_comb begin
    if (sum > 66'sh7fffffff)        sat = 32'sh7fffffff;
    else if (sum < -66'sh80000000)  sat = 32'sh80000000;
    else                            sat = sum[31:0];
  end

  // Emission source.
  assign src  = seq_src(job.ccase, k);
  always_comb begin
    unique case (src)
      SRC_A:   ov = job.a;
      SRC_B:   ov = job.b;
      SRC_C:   ov = job.c;
      SRC_X:   ov = xv;
      default: ov = yv;
    endcase
  end
  assign load  = (state == BE_EMIT) && (!out_valid || pop);
  assign empty = !out_valid;
  assign q_pop = (state == BE_IDLE) && q_nonempty;

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BE_IDLE:  if (q_nonempty)
                  state_next = (q_data.ccase == CLIP_NONE) ? BE_EMIT : BE_SETUP;
      BE_SETUP: state_next = (den == 34'sd0) ? BE_MUL : BE_DIV;
      BE_DIV:   if (cnt == '0) state_next = BE_SAT;
      BE_SAT:   state_next = BE_MUL;
      BE_MUL:   state_next = BE_ADD;
      BE_ADD:   if (comp == 3'd7) state_next = ysel ? BE_EMIT : BE_SETUP;
                else state_next = BE_MUL;
      BE_EMIT:  if (load && k == seq_len(job.ccase) - 3'd1) state_next = BE_IDLE;
      default:  state_next = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BE_IDLE;
    else     state <= state_next;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      BE_IDLE: begin
        job  <= q_data;
        ysel <= 1'b0;
        k    <= 3'd0;
      end
      BE_SETUP: begin
        comp <= 3'd0;
        if (den == 34'sd0) begin
          t <= (num == 33'sd0) ? 32'sd0 : (num > 0 ? 32'sh7fffffff : 32'sh80000000);
        end
        // magnitude is unsigned: the most negative sum needs all 33 bits
        dvd  <= NW'($unsigned(num < 0 ? -num : num)) << FRAC_BITS;
        dvs  <= 34'(den < 0 ? -den : den);
        rem  <= '0;
        cnt  <= CW'(NW - 1);
        qneg <= (num < 0) ^ (den < 0);
      end
      BE_DIV: begin
        rem <= fit ? 34'(trial - {1'b0, dvs}) : trial[33:0];
        dvd <= {dvd[NW-2:0], fit};
        cnt <= cnt - CW'(1);
      end
      BE_SAT: begin
        if (qneg) t <= (dvd > QMIN) ? 32'sh80000000 : 32'(-dvd);
        else      t <= (dvd > QMAX) ? 32'sh7fffffff : dvd[31:0];
      end
      BE_MUL: prod <= 65'(diff) * 65'(t);
      BE_ADD: begin
        if (ysel) yv[comp] <= sat;
        else      xv[comp] <= sat;
        comp <= comp + 3'd1;
        if (comp == 3'd7) ysel <= 1'b1;
      end
      BE_EMIT: if (load) k <= k + 3'd1;
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load) begin
      result.out_corner      <= (k >= 3'd3) ? 2'(k - 3'd3) : k[1:0];
      result.out_x           <= ov[0];
      result.out_y           <= ov[1];
      result.out_z           <= ov[2];
      result.out_w           <= ov[3];
      result.out_attr_0      <= ov[4];
      result.out_attr_1      <= ov[5];
      result.out_attr_2      <= ov[6];
      result.out_attr_3      <= ov[7];
      result.end_of_triangle <= (k == 3'd2) || (k == 3'd5);
      result.end_of_run      <= (k == seq_len(job.ccase) - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst)       out_valid <= 1'b0;
    else if (load) out_valid <= 1'b1;
    else if (pop)  out_valid <= 1'b0;
  end

endmodule
`default_nettype wire

FILE: hdl/ntc_checker.sv
// Port-level checks on the clipper's result stream, bound to the top level.
`default_nettype none
module ntc_checker
  import ntc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t result
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result present right after reset");

  a_corner_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.out_corner != 2'd3))
    else $error("bad output corner");

  a_tri_end: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.end_of_triangle == (result.out_corner == 2'd2)))
    else $error("end_of_triangle out of step with corner");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.end_of_run) |-> result.end_of_triangle)
    else $error("run ends inside a triangle");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result changed");

endmodule

bind near_plane_triangle_clipper ntc_checker u_ntc_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .result(result)
);
`default_nettype wire
